// ===== rtl/core/prj_pkg.sv =====
package prj_pkg;

	// light speed per microsecond, Q.16 metres
	localparam logic [24:0] C_Q16 = 25'd19647199;

	// scale of one in Q.16
	localparam logic [19:0] S_ONE = 20'd65536;

	// rounding offset for a Q.16 product
	localparam logic [63:0] HALF_Q16 = 64'd32768;

	// rounding offset for the clock term shift by 24
	localparam logic [65:0] HALF_Q24 = 66'd8388608;

	// steps of the range square root and of the switch square root
	localparam int SQ_N = 42;
	localparam int SW_N = 20;

	// steps of the switch derivative divider and of the unit vector divider
	localparam int DV_N = 48;
	localparam int DU_N = 31;

	// output widths
	localparam logic [6:0] W_RES = 7'd48;
	localparam logic [6:0] W_JAC = 7'd32;
	localparam logic [6:0] W_CLK = 7'd40;

	// side data that rides along the range square root
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][39:0] dm;
		logic [42:0]      pre;
		logic [39:0]      swx;
		logic [39:0]      swr;
	} sq_side_t;

	// state of one divider stage, both dividers side by side
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][42:0] remu;
		logic [2:0][30:0] nlu;
		logic [2:0][30:0] qu;
		logic [41:0]      norm;
		logic             deg;
		logic             eneg;
		logic [42:0]      emag;
		logic [19:0]      s;
		logic [20:0]      den;
		logic [21:0]      remw;
		logic [47:0]      nlw;
		logic [47:0]      qw;
		logic             ovf;
	} dv_t;

	// signed saturation of a sign and magnitude pair to w bits
	function automatic logic [63:0] sat_mag(input logic [63:0] m, input logic neg,
			input logic [6:0] w);
		logic [63:0] lim;
		logic [63:0] r;
		lim = (64'd1 << (w - 7'd1)) - 64'd1;
		if (neg) begin
			if (m > lim + 64'd1)
				r = ~lim;
			else
				r = ~m + 64'd1;
		end else begin
			if (m > lim)
				r = lim;
			else
				r = m;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/prj_meas_if.sv =====
interface prj_meas_if;
	logic        valid;
	logic        ready;
	logic [39:0] rx_x;
	logic [39:0] rx_y;
	logic [39:0] rx_z;
	logic [39:0] clock_bias;
	logic [39:0] sat_x;
	logic [39:0] sat_y;
	logic [39:0] sat_z;
	logic [39:0] measured_range;
	logic [23:0] switch_value;

	modport source (output valid, rx_x, rx_y, rx_z, clock_bias, sat_x, sat_y, sat_z,
		measured_range, switch_value, input ready);
	modport sink (input valid, rx_x, rx_y, rx_z, clock_bias, sat_x, sat_y, sat_z,
		measured_range, switch_value, output ready);
endinterface

// ===== rtl/core/prj_res_if.sv =====
interface prj_res_if;
	logic        valid;
	logic        ready;
	logic [47:0] residual;
	logic [31:0] jac_x;
	logic [31:0] jac_y;
	logic [31:0] jac_z;
	logic [39:0] jac_clock;
	logic [47:0] jac_switch;
	logic        degenerate;

	modport source (output valid, residual, jac_x, jac_y, jac_z, jac_clock, jac_switch,
		degenerate, input ready);
	modport sink (input valid, residual, jac_x, jac_y, jac_z, jac_clock, jac_switch,
		degenerate, output ready);
endinterface

// ===== rtl/core/pseudorange_residual_jacobian.sv =====
// Pseudorange residual and Jacobian for one satellite measurement per item.
// meas carries receiver and satellite positions, clock bias, the measured
// range and a switch weight; result carries the residual, the scaled
// line-of-sight Jacobian, the clock and switch derivatives and a flag for
// coinciding positions. cfg_we/cfg_wdata write switch_mode (0 plain,
// 1 switchable); write it only while no item is in flight.
// The pipeline has 99 register stages: 4 stages of difference, squares and
// sums, 42 stages of bit-per-stage square root, 3 stages forming the residual
// and divider numerators, 48 stages of bit-per-stage division and 2 stages of
// scaling, rounding and saturation. Throughput is one item per cycle while
// result is not stalled; the depth of the divider and square root chains sets
// the latency, every stage is registered.
// A stall on result freezes the whole pipeline in place: meas.ready follows
// result.ready whenever the output register is full, so nothing is dropped
// or repeated. Reset clears all valid bits and switch_mode.
module pseudorange_residual_jacobian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	prj_meas_if.sink           meas,
	prj_res_if.source          result
);

	localparam int SQ_N = prj_pkg::SQ_N;
	localparam int DV_N = prj_pkg::DV_N;

	logic switch_mode_q;
	logic adv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			switch_mode_q <= 1'b0;
		else if (cfg_we)
			switch_mode_q <= cfg_wdata;
	end

	// global advance: the pipeline moves unless the output register is held
	logic v_s99;
	assign adv = !v_s99 || result.ready;
	assign meas.ready = adv;

	// stage 1: position differences, magnitudes, clock magnitude, clamped switch
	logic [40:0] d_c [3];
	logic [39:0] cb_mag_c;

	always_comb begin
		d_c[0] = {meas.rx_x[39], meas.rx_x} - {meas.sat_x[39], meas.sat_x};
		d_c[1] = {meas.rx_y[39], meas.rx_y} - {meas.sat_y[39], meas.sat_y};
		d_c[2] = {meas.rx_z[39], meas.rx_z} - {meas.sat_z[39], meas.sat_z};
		cb_mag_c = meas.clock_bias[39] ? (~meas.clock_bias + 40'd1) : meas.clock_bias;
	end

	logic             v_s1;
	logic [2:0]       neg_s1;
	logic [2:0][39:0] dm_s1;
	logic             cneg_s1;
	logic [39:0]      cmag_s1;
	logic [39:0]      meas_s1;
	logic [22:0]      sw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= meas.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= d_c[i][40];
				dm_s1[i]  <= d_c[i][40] ? 40'(~d_c[i] + 41'd1) : d_c[i][39:0];
			end
			cneg_s1 <= meas.clock_bias[39];
			cmag_s1 <= cb_mag_c;
			meas_s1 <= meas.measured_range;
			sw_s1   <= meas.switch_value[23] ? 23'd0 : meas.switch_value[22:0];
		end
	end

	// stage 2: partial products of the squares and of the clock term
	logic             v_s2;
	logic [2:0]       neg_s2;
	logic [2:0][39:0] dm_s2;
	logic [2:0][39:0] hh_s2;
	logic [2:0][39:0] hl_s2;
	logic [2:0][39:0] ll_s2;
	logic [44:0]      ch_s2;
	logic [44:0]      cl_s2;
	logic             cneg_s2;
	logic [39:0]      meas_s2;
	logic [22:0]      sw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				hh_s2[i] <= dm_s1[i][39:20] * dm_s1[i][39:20];
				hl_s2[i] <= dm_s1[i][39:20] * dm_s1[i][19:0];
				ll_s2[i] <= dm_s1[i][19:0] * dm_s1[i][19:0];
			end
			ch_s2   <= cmag_s1[39:20] * prj_pkg::C_Q16;
			cl_s2   <= cmag_s1[19:0] * prj_pkg::C_Q16;
			neg_s2  <= neg_s1;
			dm_s2   <= dm_s1;
			cneg_s2 <= cneg_s1;
			meas_s2 <= meas_s1;
			sw_s2   <= sw_s1;
		end
	end

	// stage 3: squares per axis and rounded clock term magnitude
	logic             v_s3;
	logic [2:0]       neg_s3;
	logic [2:0][39:0] dm_s3;
	logic [2:0][79:0] sq_s3;
	logic [41:0]      cm_s3;
	logic             cneg_s3;
	logic [39:0]      meas_s3;
	logic [22:0]      sw_s3;
	logic [65:0]      csum_c;

	assign csum_c = (66'(ch_s2) << 20) + 66'(cl_s2) + prj_pkg::HALF_Q24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= (80'(hh_s2[i]) << 40) + (80'(hl_s2[i]) << 21) + 80'(ll_s2[i]);
			cm_s3   <= csum_c[65:24];
			neg_s3  <= neg_s2;
			dm_s3   <= dm_s2;
			cneg_s3 <= cneg_s2;
			meas_s3 <= meas_s2;
			sw_s3   <= sw_s2;
		end
	end

	// stage 4: sum of squares, clock term minus measurement
	logic                v_s4;
	logic [83:0]         sum_s4;
	prj_pkg::sq_side_t   sd_s4;
	logic [42:0]         cterm_c;

	assign cterm_c = cneg_s3 ? (~{1'b0, cm_s3} + 43'd1) : {1'b0, cm_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4    <= 84'(sq_s3[0]) + 84'(sq_s3[1]) + 84'(sq_s3[2]);
			sd_s4.neg <= neg_s3;
			sd_s4.dm  <= dm_s3;
			sd_s4.pre <= cterm_c - {{3{meas_s3[39]}}, meas_s3};
			sd_s4.swx <= 40'(sw_s3) << 16;
			sd_s4.swr <= 40'd0;
		end
	end

	// stages 5 to 46: range square root one bit per stage, switch root alongside
	logic                v_sq_s5  [SQ_N];
	logic [83:0]         x_sq_s5  [SQ_N];
	logic [83:0]         r_sq_s5  [SQ_N];
	prj_pkg::sq_side_t   sd_sq_s5 [SQ_N];

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [83:0] BIT = 84'd1 << (2 * (SQ_N - 1 - k));
		logic                v_in;
		logic [83:0]         x_in;
		logic [83:0]         r_in;
		prj_pkg::sq_side_t   sd_in;
		logic [83:0]         trial;
		logic [83:0]         x_nx;
		logic [83:0]         r_nx;
		prj_pkg::sq_side_t   sd_nx;

		if (k == 0) begin : g_first
			assign v_in  = v_s4;
			assign x_in  = sum_s4;
			assign r_in  = 84'd0;
			assign sd_in = sd_s4;
		end else begin : g_next
			assign v_in  = v_sq_s5[k-1];
			assign x_in  = x_sq_s5[k-1];
			assign r_in  = r_sq_s5[k-1];
			assign sd_in = sd_sq_s5[k-1];
		end

		// one digit of the range root
		always_comb begin
			trial = r_in + BIT;
			if (x_in >= trial) begin
				x_nx = x_in - trial;
				r_nx = (r_in >> 1) + BIT;
			end else begin
				x_nx = x_in;
				r_nx = r_in >> 1;
			end
		end

		// one digit of the switch root in the first stages
		if (k < prj_pkg::SW_N) begin : g_sw
			localparam logic [39:0] SBIT = 40'd1 << (2 * (prj_pkg::SW_N - 1 - k));
			logic [39:0] strial;
			always_comb begin
				strial = sd_in.swr + SBIT;
				sd_nx  = sd_in;
				if (sd_in.swx >= strial) begin
					sd_nx.swx = sd_in.swx - strial;
					sd_nx.swr = (sd_in.swr >> 1) + SBIT;
				end else begin
					sd_nx.swr = sd_in.swr >> 1;
				end
			end
		end else begin : g_hold
			assign sd_nx = sd_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq_s5[k] <= 1'b0;
			else if (adv)
				v_sq_s5[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_sq_s5[k]  <= x_nx;
				r_sq_s5[k]  <= r_nx;
				sd_sq_s5[k] <= sd_nx;
			end
		end
	end

	// stage 47: residual before scaling, unit vector numerators, scale
	prj_pkg::sq_side_t sd_end;
	logic [41:0]       norm_c;

	assign sd_end = sd_sq_s5[SQ_N-1];
	assign norm_c = r_sq_s5[SQ_N-1][41:0];

	logic             v_s47;
	logic [43:0]      e_s47;
	logic [19:0]      s_s47;
	logic [2:0][70:0] numu_s47;
	logic [2:0]       neg_s47;
	logic [41:0]      norm_s47;
	logic             deg_s47;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s47 <= 1'b0;
		else if (adv)
			v_s47 <= v_sq_s5[SQ_N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s47 <= {2'b00, norm_c} + {sd_end.pre[42], sd_end.pre};
			s_s47 <= switch_mode_q ? sd_end.swr[19:0] : prj_pkg::S_ONE;
			for (int i = 0; i < 3; i++)
				numu_s47[i] <= {1'b0, sd_end.dm[i], 30'd0} + 71'(norm_c >> 1);
			neg_s47  <= sd_end.neg;
			norm_s47 <= norm_c;
			deg_s47  <= (norm_c == 42'd0);
		end
	end

	// stage 48: residual magnitude and switch divisor
	logic             v_s48;
	logic [42:0]      emag_s48;
	logic             eneg_s48;
	logic [20:0]      den_s48;
	logic [19:0]      s_s48;
	logic [2:0][70:0] numu_s48;
	logic [2:0]       neg_s48;
	logic [41:0]      norm_s48;
	logic             deg_s48;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s48 <= 1'b0;
		else if (adv)
			v_s48 <= v_s47;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emag_s48 <= e_s47[43] ? 43'(~e_s47 + 44'd1) : e_s47[42:0];
			eneg_s48 <= e_s47[43];
			den_s48  <= 21'(s_s47) + 21'd1;
			s_s48    <= s_s47;
			numu_s48 <= numu_s47;
			neg_s48  <= neg_s47;
			norm_s48 <= norm_s47;
			deg_s48  <= deg_s47;
		end
	end

	// stage 49: switch derivative numerator
	logic             v_s49;
	logic [58:0]      nw_s49;
	logic [42:0]      emag_s49;
	logic             eneg_s49;
	logic [20:0]      den_s49;
	logic [19:0]      s_s49;
	logic [2:0][70:0] numu_s49;
	logic [2:0]       neg_s49;
	logic [41:0]      norm_s49;
	logic             deg_s49;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s49 <= 1'b0;
		else if (adv)
			v_s49 <= v_s48;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nw_s49   <= (59'(emag_s48) << 15) + 59'(den_s48 >> 1);
			emag_s49 <= emag_s48;
			eneg_s49 <= eneg_s48;
			den_s49  <= den_s48;
			s_s49    <= s_s48;
			numu_s49 <= numu_s48;
			neg_s49  <= neg_s48;
			norm_s49 <= norm_s48;
			deg_s49  <= deg_s48;
		end
	end

	// divider start: high numerator bits form the first partial remainders
	prj_pkg::dv_t dv_init;

	always_comb begin
		dv_init      = '0;
		dv_init.neg  = neg_s49;
		for (int i = 0; i < 3; i++) begin
			dv_init.remu[i] = {3'b000, numu_s49[i][70:31]};
			dv_init.nlu[i]  = numu_s49[i][30:0];
		end
		dv_init.norm = norm_s49;
		dv_init.deg  = deg_s49;
		dv_init.eneg = eneg_s49;
		dv_init.emag = emag_s49;
		dv_init.s    = s_s49;
		dv_init.den  = den_s49;
		dv_init.remw = 22'(nw_s49[58:48]);
		dv_init.nlw  = nw_s49[47:0];
		dv_init.ovf  = (21'(nw_s49[58:48]) >= den_s49);
	end

	// stages 50 to 97: restoring division one quotient bit per stage
	logic         v_dv_s50 [DV_N];
	prj_pkg::dv_t dv_s50   [DV_N];

	for (genvar k = 0; k < DV_N; k++) begin : g_div
		logic         v_in;
		prj_pkg::dv_t p;
		prj_pkg::dv_t n;
		logic [21:0]  tw;

		if (k == 0) begin : g_first
			assign v_in = v_s49;
			assign p    = dv_init;
		end else begin : g_next
			assign v_in = v_dv_s50[k-1];
			assign p    = dv_s50[k-1];
		end

		// switch derivative quotient bit
		always_comb begin
			n  = p;
			tw = {p.remw[20:0], p.nlw[DV_N-1-k]};
			if (tw >= {1'b0, p.den}) begin
				n.remw = tw - {1'b0, p.den};
				n.qw[DV_N-1-k] = 1'b1;
			end else begin
				n.remw = tw;
			end
		end

		// unit vector quotient bits in the first stages
		prj_pkg::dv_t n2;
		if (k < prj_pkg::DU_N) begin : g_unit
			logic [42:0] tu [3];
			always_comb begin
				n2 = n;
				for (int i = 0; i < 3; i++) begin
					tu[i] = {p.remu[i][41:0], p.nlu[i][prj_pkg::DU_N-1-k]};
					if (tu[i] >= {1'b0, p.norm}) begin
						n2.remu[i] = tu[i] - {1'b0, p.norm};
						n2.qu[i][prj_pkg::DU_N-1-k] = 1'b1;
					end else begin
						n2.remu[i] = tu[i];
					end
				end
			end
		end else begin : g_hold
			assign n2 = n;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_dv_s50[k] <= 1'b0;
			else if (adv)
				v_dv_s50[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv)
				dv_s50[k] <= n2;
		end
	end

	// stage 98: scaling products
	prj_pkg::dv_t dv_end;
	assign dv_end = dv_s50[DV_N-1];

	logic             v_s98;
	logic [41:0]      peh_s98;
	logic [40:0]      pel_s98;
	logic [2:0][50:0] pu_s98;
	logic [44:0]      pc_s98;
	logic [2:0]       neg_s98;
	logic             eneg_s98;
	logic             deg_s98;
	logic [47:0]      qw_s98;
	logic             ovf_s98;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s98 <= 1'b0;
		else if (adv)
			v_s98 <= v_dv_s50[DV_N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			peh_s98 <= dv_end.emag[42:21] * dv_end.s;
			pel_s98 <= dv_end.emag[20:0] * dv_end.s;
			for (int i = 0; i < 3; i++)
				pu_s98[i] <= dv_end.qu[i] * dv_end.s;
			pc_s98   <= prj_pkg::C_Q16 * dv_end.s;
			neg_s98  <= dv_end.neg;
			eneg_s98 <= dv_end.eneg;
			deg_s98  <= dv_end.deg;
			qw_s98   <= dv_end.qw;
			ovf_s98  <= dv_end.ovf;
		end
	end

	// stage 99: rounding, sign and saturation into the output register
	logic [63:0] me_c;
	logic [63:0] mu_c [3];
	logic [63:0] mc_c;
	logic [63:0] mw_c;
	logic [63:0] res_c;
	logic [63:0] ju_c [3];
	logic [63:0] jc_c;
	logic [63:0] jw_c;

	always_comb begin
		me_c  = ((64'(peh_s98) << 21) + 64'(pel_s98) + prj_pkg::HALF_Q16) >> 16;
		res_c = prj_pkg::sat_mag(me_c, eneg_s98, prj_pkg::W_RES);
		for (int i = 0; i < 3; i++) begin
			mu_c[i] = (64'(pu_s98[i]) + prj_pkg::HALF_Q16) >> 16;
			ju_c[i] = deg_s98 ? 64'd0 : prj_pkg::sat_mag(mu_c[i], neg_s98[i], prj_pkg::W_JAC);
		end
		mc_c = (64'(pc_s98) + prj_pkg::HALF_Q16) >> 16;
		jc_c = prj_pkg::sat_mag(mc_c, 1'b0, prj_pkg::W_CLK);
		mw_c = ovf_s98 ? '1 : 64'(qw_s98);
		jw_c = switch_mode_q ? prj_pkg::sat_mag(mw_c, eneg_s98, prj_pkg::W_RES) : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s99 <= 1'b0;
		else if (adv)
			v_s99 <= v_s98;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.residual   <= res_c[47:0];
			result.jac_x      <= ju_c[0][31:0];
			result.jac_y      <= ju_c[1][31:0];
			result.jac_z      <= ju_c[2][31:0];
			result.jac_clock  <= jc_c[39:0];
			result.jac_switch <= jw_c[47:0];
			result.degenerate <= deg_s98;
		end
	end

	assign result.valid = v_s99;

endmodule

// ===== dv/prj_scoreboard.sv =====
`timescale 1ns / 100ps

module prj_scoreboard (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	prj_meas_if  meas,
	prj_res_if   result,
	output int   errors,
	output int   pending,
	output int   results,
	output int   degen_seen,
	output int   switched_items
);

	typedef struct packed {
		logic [39:0] rx_x;
		logic [39:0] rx_y;
		logic [39:0] rx_z;
		logic [39:0] clock_bias;
		logic [39:0] sat_x;
		logic [39:0] sat_y;
		logic [39:0] sat_z;
		logic [39:0] measured_range;
		logic [23:0] switch_value;
	} meas_t;

	typedef struct packed {
		logic [47:0] residual;
		logic [31:0] jac_x;
		logic [31:0] jac_y;
		logic [31:0] jac_z;
		logic [39:0] jac_clock;
		logic [47:0] jac_switch;
		logic        degenerate;
	} solution_t;

	solution_t  solution_q[$];
	logic       mode_mirror;

	function automatic logic [63:0] absv(input logic signed [63:0] a);
		return a < 0 ? -a : a;
	endfunction

	// floor square root, bit by bit
	function automatic logic [63:0] root(input logic [127:0] v);
		logic [127:0] r;
		logic [127:0] c;
		r = 0;
		for (int b = 41; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v)
				r = c;
		end
		return r[63:0];
	endfunction

	// a * s / 2^16, rounded half away from zero
	function automatic logic signed [63:0] scale_q16(input logic signed [63:0] a,
			input logic [63:0] s);
		logic [127:0] q;
		q = ({64'd0, absv(a)} * {64'd0, s} + 128'd32768) >> 16;
		return a < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [63:0] clip(input logic signed [63:0] v, input int w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic solution_t solve_measurement(input meas_t m, input logic sw_mode);
		logic signed [63:0] d[3];
		logic signed [63:0] u[3];
		logic signed [63:0] clkb;
		logic signed [63:0] cterm;
		logic signed [63:0] e;
		logic signed [63:0] swv;
		logic signed [63:0] jsw;
		logic signed [63:0] t;
		logic [127:0] sum;
		logic [127:0] q;
		logic [63:0]  norm;
		logic [63:0]  s;
		logic [63:0]  den;
		solution_t    r;
		d[0] = $signed(m.rx_x);
		d[0] = d[0] - $signed(m.sat_x);
		d[1] = $signed(m.rx_y);
		d[1] = d[1] - $signed(m.sat_y);
		d[2] = $signed(m.rx_z);
		d[2] = d[2] - $signed(m.sat_z);
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum = sum + {64'd0, absv(d[i])} * {64'd0, absv(d[i])};
		norm = root(sum);

		// range plus light-speed clock term minus measurement
		clkb = $signed(m.clock_bias);
		q = ({64'd0, absv(clkb)} * 128'(prj_pkg::C_Q16) + 128'd8388608) >> 24;
		cterm = clkb < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
		t = $signed(m.measured_range);
		e = $signed(norm) + cterm - t;

		// line of sight, zero when positions coincide
		for (int i = 0; i < 3; i++) begin
			u[i] = 0;
			if (norm != 0) begin
				q = (({64'd0, absv(d[i])} << 30) + {64'd0, norm >> 1}) / {64'd0, norm};
				u[i] = d[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
			end
		end

		// switch scale and its derivative
		if (sw_mode) begin
			swv = $signed(m.switch_value);
			if (swv < 0)
				swv = 0;
			s = root({64'd0, swv} << 16);
			den = s + 64'd1;
			q = (({64'd0, absv(e)} << 15) + {64'd0, den >> 1}) / {64'd0, den};
			jsw = e < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
		end else begin
			s = 64'd65536;
			jsw = 0;
		end

		t = clip(scale_q16(e, s), 48);
		r.residual = t[47:0];
		t = clip(scale_q16(u[0], s), 32);
		r.jac_x = t[31:0];
		t = clip(scale_q16(u[1], s), 32);
		r.jac_y = t[31:0];
		t = clip(scale_q16(u[2], s), 32);
		r.jac_z = t[31:0];
		t = clip(scale_q16(64'(prj_pkg::C_Q16), s), 40);
		r.jac_clock = t[39:0];
		t = clip(jsw, 48);
		r.jac_switch = t[47:0];
		r.degenerate = norm == 0;
		return r;
	endfunction

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch in %s of result %0d: got %h, expected %h",
			field, results, got, want);
		errors++;
	endtask

	// register mirror, input capture and output compare
	always @(posedge clk or negedge arst_n) begin
		meas_t     m;
		solution_t want;
		if (!arst_n) begin
			mode_mirror = 1'b0;
		end else begin
			if (meas.valid && meas.ready) begin
				m = '{meas.rx_x, meas.rx_y, meas.rx_z, meas.clock_bias, meas.sat_x,
					meas.sat_y, meas.sat_z, meas.measured_range, meas.switch_value};
				solution_q.push_back(solve_measurement(m, mode_mirror));
				if (mode_mirror)
					switched_items++;
			end
			if (result.valid && result.ready) begin
				if (solution_q.size() == 0) begin
					$display("result %0d arrived with no transfer pending", results);
					errors++;
				end else begin
					want = solution_q.pop_front();
					if (result.residual !== want.residual)
						report("residual", result.residual, want.residual);
					if (result.jac_x !== want.jac_x)
						report("jac_x", result.jac_x, want.jac_x);
					if (result.jac_y !== want.jac_y)
						report("jac_y", result.jac_y, want.jac_y);
					if (result.jac_z !== want.jac_z)
						report("jac_z", result.jac_z, want.jac_z);
					if (result.jac_clock !== want.jac_clock)
						report("jac_clock", result.jac_clock, want.jac_clock);
					if (result.jac_switch !== want.jac_switch)
						report("jac_switch", result.jac_switch, want.jac_switch);
					if (result.degenerate !== want.degenerate)
						report("degenerate", result.degenerate, want.degenerate);
					if (want.degenerate)
						degen_seen++;
				end
				results++;
			end
			if (cfg_we)
				mode_mirror = cfg_wdata;
		end
		pending = solution_q.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		results = 0;
		degen_seen = 0;
		switched_items = 0;
	end

endmodule

// ===== dv/pseudorange_residual_jacobian_tb.sv =====
`timescale 1ns / 100ps

module pseudorange_residual_jacobian_tb;

	localparam logic [39:0] POS_MAX = 40'h7FFFFFFFFF;
	localparam logic [39:0] NEG_MAX = 40'h8000000000;
	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	int   errors, pending, results, degen_seen, switched_items;
	int   sent = 0;
	int   idle_cycles = 0;

	prj_meas_if meas();
	prj_res_if  result();

	pseudorange_residual_jacobian dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.meas      (meas),
		.result    (result)
	);

	prj_scoreboard chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.meas           (meas),
		.result         (result),
		.errors         (errors),
		.pending        (pending),
		.results        (results),
		.degen_seen     (degen_seen),
		.switched_items (switched_items)
	);

	always #4 clk = ~clk;

	// result side: random back-pressure bursts and one long hold-off
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result.ready = 1'b0;
				repeat (399) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result.ready = 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				result.ready = 1'b1;
			end
		end
	end

	// nothing transferred for too long
	always @(posedge clk) begin
		if ((meas.valid && meas.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [39:0] rand40();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[39:0];
	endfunction

	// random signed value of the given width, sign extended
	function automatic logic [39:0] rand_signed(input int bits);
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		v = (v <<< (64 - bits)) >>> (64 - bits);
		return v[39:0];
	endfunction

	// offer one item, called at a falling edge
	task automatic offer(input logic [39:0] rx, ry, rz, cb, sx, sy, sz, mr,
			input logic [23:0] sw);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			meas.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		meas.rx_x = rx;
		meas.rx_y = ry;
		meas.rx_z = rz;
		meas.clock_bias = cb;
		meas.sat_x = sx;
		meas.sat_y = sy;
		meas.sat_z = sz;
		meas.measured_range = mr;
		meas.switch_value = sw;
		meas.valid = 1'b1;
		@(posedge clk);
		while (!meas.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		meas.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// extremes, axis-aligned lines of sight, coinciding positions, switch signs
	task automatic directed_items();
		offer(0, 0, 0, 0, 0, 0, 0, 0, 24'h000000);
		offer(POS_MAX, POS_MAX, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
			24'h7FFFFF);
		offer(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
			24'h800000);
		offer(40'd123456, -40'sd99, 40'd7, 40'd1000, 40'd123456, -40'sd99, 40'd7,
			40'd5000, 24'h010000);
		offer(POS_MAX, NEG_MAX, 0, NEG_MAX, POS_MAX, NEG_MAX, 0, POS_MAX, 24'h7FFFFF);
		offer(40'd256, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
		offer(0, -40'sd65536, 0, 40'd65536, 0, 0, 0, 40'd65536, 24'h040000);
		offer(0, 0, 40'd1, 0, 0, 0, 0, 40'd1, 24'h000001);
		offer(-40'sd1, 0, 0, -40'sd1, 0, 0, 0, -40'sd1, 24'h000002);
		offer(40'd3, 40'd4, 0, 0, 0, 0, 0, 40'd5, 24'h400000);
		offer(40'h0FFFFFFFFF, 40'h0FFFFFFFFF, 40'h0FFFFFFFFF, 40'h00FFFFFFFF,
			40'hF000000000, 40'hF000000000, 40'hF000000000, 0, 24'h7FFFFF);
		offer(POS_MAX, 0, 0, 0, 0, 0, 0, NEG_MAX, 24'hFFFFFF);
	endtask

	// mostly receiver-near-satellite geometry, some coinciding, some raw noise
	task automatic random_items(input int count);
		logic [39:0] rx, ry, rz, sx, sy, sz, mr;
		logic [23:0] sw;
		int kind;
		repeat (count) begin
			kind = $urandom_range(0, 9);
			if (kind <= 1) begin
				rx = rand40();
				ry = rand40();
				rz = rand40();
				sx = rand40();
				sy = rand40();
				sz = rand40();
				mr = rand40();
			end else begin
				rx = rand_signed(31);
				ry = rand_signed(31);
				rz = rand_signed(31);
				if (kind == 2) begin
					sx = rx;
					sy = ry;
					sz = rz;
				end else begin
					sx = rx + rand_signed($urandom_range(2, 38));
					sy = ry + rand_signed($urandom_range(2, 38));
					sz = rz + rand_signed($urandom_range(2, 38));
				end
				mr = rand_signed($urandom_range(8, 40));
			end
			if ($urandom_range(0, 9) < 7)
				sw = 24'($urandom_range(0, 24'h020000));
			else
				sw = 24'($urandom);
			offer(rx, ry, rz, kind == 0 ? rand40() : rand_signed($urandom_range(1, 40)),
				sx, sy, sz, mr, sw);
		end
	endtask

	initial begin
		meas.valid = 1'b0;
		meas.rx_x = '0;
		meas.rx_y = '0;
		meas.rx_z = '0;
		meas.clock_bias = '0;
		meas.sat_x = '0;
		meas.sat_y = '0;
		meas.sat_z = '0;
		meas.measured_range = '0;
		meas.switch_value = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_mode(1'b0);
		directed_items();
		write_mode(1'b1);
		directed_items();

		// long hold-off on the result side while items keep coming
		write_mode(1'b1);
		hold_req = 1'b1;
		random_items(400);
		write_mode(1'b0);
		random_items(400);
		write_mode(1'b1);
		random_items(400);

		// closing stretch without idling
		write_mode(1'b0);
		quiet = 1'b1;
		random_items(350);
		drain();
		repeat (120) @(negedge clk);

		$display("%0d items sent, %0d results checked, %0d in switchable mode",
			sent, results, switched_items);
		$display("%0d coinciding-position results, %0d mismatches", degen_seen, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
